@@ src/char_cell_grid_writer_core_defines.svh @@
// Assertion macros for the character cell grid writer.
`ifndef CHAR_CELL_GRID_WRITER_CORE_DEFINES_SVH
`define CHAR_CELL_GRID_WRITER_CORE_DEFINES_SVH

// Condition and consequence in the same cycle.
`define CCGW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define CCGW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ccgw_pkg.sv @@
// Shared types and constants of the character cell grid writer.
package ccgw_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;

  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] W_CONT   = 2'd0;
  localparam logic [1:0] W_NARROW = 2'd1;
  localparam logic [1:0] W_WIDE   = 2'd2;

  localparam logic [20:0] CP_SPACE = 21'h20;

  localparam logic [2:0] REG_VIEW_X = 3'd0;
  localparam logic [2:0] REG_VIEW_Y = 3'd1;
  localparam logic [2:0] REG_VIEW_W = 3'd2;
  localparam logic [2:0] REG_VIEW_H = 3'd3;
  localparam logic [2:0] REG_SURF_W = 3'd4;
  localparam logic [2:0] REG_SURF_H = 3'd5;

  typedef struct packed {
    logic [7:0]  attrs;
    logic [23:0] bg;
    logic [23:0] fg;
    logic [1:0]  width;
    logic [20:0] cp;
  } cell_t;

  typedef struct packed {
    logic [7:0]  attrs;
    logic [23:0] bg;
    logic [23:0] fg;
    logic [1:0]  glyph_width;
    logic [20:0] glyph;
    logic [6:0]  y;
    logic [7:0]  x;
  } in_data_t;

  localparam cell_t BLANK_CELL = '{
    attrs: 8'd0, bg: 24'd0, fg: 24'd0, width: W_NARROW, cp: CP_SPACE
  };

endpackage

@@ src/char_cell_grid_writer_core.sv @@
// Character cell grid writer: clipped put, fill and read on a cell memory.
// After reset a clearing pass writes a blank to all 8192 cells, one a cycle; no item is taken.
// The cells sit in one single-port memory, so an item runs in steps: it is accepted, then its
// left and right neighbors are read (a read op reads only its own cell), then its cell writes follow
// one by one; a rejected item goes straight to its result. No new item is taken until then; the result is registered.
`include "char_cell_grid_writer_core_defines.svh"

module char_cell_grid_writer_core import ccgw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // x, y, glyph, glyph_width, fg, bg, attrs (from bit 0), two zero bits on top
  input  logic [95:0] in_tdata,
  // op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_char, read_width, read_fg, read_bg, read_attrs (from bit 0), one zero bit on top
  output logic [79:0] out_tdata,
  // done_res
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RDL  = 6'b000100,
    S_RDR  = 6'b001000,
    S_WR1  = 6'b010000,
    S_WR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0] view_x_r;
  logic [5:0] view_y_r;
  logic [7:0] view_w_r;
  logic [6:0] view_h_r;
  logic [7:0] surf_w_r;
  logic [6:0] surf_h_r;

  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic             is_rd_r, done_r, wide_r, left_en_r, right_en_r;
  logic [COL_W-1:0] ox_r;
  logic [ROW_W-1:0] oy_r;
  cell_t            head_r;
  logic             pl_r, pr_r, ph_r, pc_r;
  logic             pl_nxt, pr_nxt, ph_nxt, pc_nxt;

  logic  out_valid_r, out_valid_nxt;
  logic  out_done_r;
  cell_t out_data_r;
  logic  finish;

  cell_t cell_mem [CELLS];
  cell_t rd_q_r;
  logic  mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  cell_t mem_wdata;

  in_data_t   din;
  logic       accept;
  logic [8:0] ox_full;
  logic [7:0] oy_full;
  logic [7:0] eff_w;
  logic [6:0] eff_h;
  logic       addr_ok, wide_fit, is_wide, is_narrow, wide_mode;
  logic       acc_do_w, acc_rd, acc_right_en;
  cell_t      acc_head;

  logic [3:0]       pend, sel, rest;
  logic             pr_eff, last, fin_ok, wr_go;
  logic [COL_W-1:0] rpos;
  cell_t            cont_cell;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_VIEW_X: cfg_prdata = {25'd0, view_x_r};
      REG_VIEW_Y: cfg_prdata = {26'd0, view_y_r};
      REG_VIEW_W: cfg_prdata = {24'd0, view_w_r};
      REG_VIEW_H: cfg_prdata = {25'd0, view_h_r};
      REG_SURF_W: cfg_prdata = {24'd0, surf_w_r};
      REG_SURF_H: cfg_prdata = {25'd0, surf_h_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r <= 7'd0;
      view_y_r <= 6'd0;
      view_w_r <= 8'd80;
      view_h_r <= 7'd25;
      surf_w_r <= 8'd80;
      surf_h_r <= 7'd25;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_VIEW_X: view_x_r <= cfg_pwdata[6:0];
        REG_VIEW_Y: view_y_r <= cfg_pwdata[5:0];
        REG_VIEW_W: view_w_r <= cfg_pwdata[7:0];
        REG_VIEW_H: view_h_r <= cfg_pwdata[6:0];
        REG_SURF_W: surf_w_r <= cfg_pwdata[7:0];
        REG_SURF_H: surf_h_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  assign din       = in_data_t'(in_tdata[93:0]);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Clip to the view, move by the view origin and clip to the surface in use.
  assign ox_full   = {2'b00, view_x_r} + {1'b0, din.x};
  assign oy_full   = {2'b00, view_y_r} + {1'b0, din.y};
  assign eff_w     = (surf_w_r > 8'(MAX_COLS)) ? 8'(MAX_COLS) : surf_w_r;
  assign eff_h     = (surf_h_r > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : surf_h_r;
  assign addr_ok   = (din.x < view_w_r) && (din.y < view_h_r) &&
                     (ox_full < {1'b0, eff_w}) && (oy_full < {1'b0, eff_h});
  assign wide_fit  = (({1'b0, din.x} + 9'd1) < {1'b0, view_w_r}) &&
                     ((ox_full + 9'd1) < {1'b0, eff_w});
  assign is_wide   = (din.glyph_width == W_WIDE);
  assign is_narrow = (din.glyph_width == W_NARROW);
  assign wide_mode = (in_tuser == OP_PUT) && is_wide;
  assign acc_right_en = wide_mode ? ((ox_full + 9'd2) < {1'b0, eff_w})
                                  : ((ox_full + 9'd1) < {1'b0, eff_w});

  always_comb begin
    acc_do_w = 1'b0;
    acc_rd   = 1'b0;
    acc_head = '{attrs: din.attrs, bg: din.bg, fg: din.fg, width: W_NARROW, cp: CP_SPACE};
    unique case (in_tuser)
      OP_PUT: begin
        acc_do_w       = addr_ok && (is_narrow || (is_wide && wide_fit));
        acc_head.width = din.glyph_width;
        acc_head.cp    = din.glyph;
      end
      OP_FILL: acc_do_w = addr_ok;
      OP_READ: acc_rd   = addr_ok;
      default: ;
    endcase
  end

  assign rpos      = ox_r + (wide_r ? COL_W'(2) : COL_W'(1));
  assign cont_cell = '{attrs: 8'd0, bg: head_r.bg, fg: 24'd0, width: W_CONT, cp: CP_SPACE};
  assign fin_ok    = !out_valid_r || out_tready;

  // Pending writes, lowest bit first: left blank, right blank, head, continuation.
  assign pr_eff = (state_r == S_WR1) ? (right_en_r && (rd_q_r.width == W_CONT)) : pr_r;
  assign pend   = {pc_r, ph_r, pr_eff, pl_r};
  assign sel    = pend & (~pend + 4'd1);
  assign rest   = pend & ~sel;
  assign last   = (rest == 4'd0);
  assign wr_go  = !last || fin_ok;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pl_nxt        = pl_r;
    pr_nxt        = pr_r;
    ph_nxt        = ph_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    finish        = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = {oy_r, ox_r};
    mem_wdata     = BLANK_CELL;
    unique case (state_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pl_nxt    = 1'b0;
          pr_nxt    = 1'b0;
          ph_nxt    = acc_do_w;
          pc_nxt    = acc_do_w && wide_mode;
          state_nxt = (acc_do_w || acc_rd) ? S_RDL : S_WR;
        end
      end
      S_RDL: begin
        mem_re    = 1'b1;
        mem_addr  = {oy_r, is_rd_r ? ox_r : (ox_r - COL_W'(1))};
        state_nxt = is_rd_r ? S_WR : S_RDR;
      end
      S_RDR: begin
        mem_re    = 1'b1;
        mem_addr  = {oy_r, rpos};
        pl_nxt    = left_en_r && (rd_q_r.width == W_WIDE);
        state_nxt = S_WR1;
      end
      S_WR1, S_WR: begin
        if (wr_go) begin
          {pc_nxt, ph_nxt, pr_nxt, pl_nxt} = rest;
          mem_we = |sel;
          priority if (sel[0]) begin
            mem_addr = {oy_r, ox_r - COL_W'(1)};
          end else if (sel[1]) begin
            mem_addr = {oy_r, rpos};
          end else if (sel[2]) begin
            mem_addr  = {oy_r, ox_r};
            mem_wdata = head_r;
          end else begin
            mem_addr  = {oy_r, ox_r + COL_W'(1)};
            mem_wdata = cont_cell;
          end
          if (last) begin
            finish        = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_WR;
          end
        end else begin
          {pc_nxt, ph_nxt, pr_nxt, pl_nxt} = pend;
          state_nxt = S_WR;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= cell_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      pl_r        <= 1'b0;
      pr_r        <= 1'b0;
      ph_r        <= 1'b0;
      pc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pl_r        <= pl_nxt;
      pr_r        <= pr_nxt;
      ph_r        <= ph_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_rd_r    <= acc_rd;
      done_r     <= acc_do_w || acc_rd;
      wide_r     <= wide_mode;
      left_en_r  <= (ox_full != 9'd0);
      right_en_r <= acc_right_en;
      ox_r       <= ox_full[COL_W-1:0];
      oy_r       <= oy_full[ROW_W-1:0];
      head_r     <= acc_head;
    end
    if (finish) begin
      out_done_r <= done_r;
      out_data_r <= (is_rd_r && done_r) ? rd_q_r : cell_t'('0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_done_r;
  assign out_tdata  = {1'b0, out_data_r};

  `CCGW_ASSERT_NOW(a_one_port, mem_we, !mem_re, "cell memory read and written in one cycle")
  `CCGW_ASSERT_NOW(a_fail_zero, out_tvalid && !out_tuser, out_tdata == 80'd0, "failed item has data")
  `CCGW_ASSERT_NEXT(a_busy_after, accept, !in_tready, "item taken while previous one is at work")

endmodule
